// File: rtl/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// shared types and constants of the histogram bhattacharyya distance block
// ----------------------------------------------------------------------------
`default_nettype none

package hbd_pkg;

    // result format: unsigned q0.16, 1.0 needs a 17th bit
    localparam int DIST_W      = 17;
    localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;
    localparam int RATIO_SHIFT = 16;
    // fraction pairs of the final root: sqrt(x * 2^16) over a q0.16 x
    localparam int DIST_FRAC   = 8;
    localparam logic [DIST_W-1:0] ONE_Q16 = 17'h10000;

    // short queue between front and back
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // finishing sequencer
    typedef enum logic [3:0] {
        FIN_IDLE,
        FIN_MUL,
        FIN_DSTART,
        FIN_DROOT,
        FIN_DIV,
        FIN_CLAMP,
        FIN_QSTART,
        FIN_QROOT,
        FIN_DONE
    } t_fin_state;

endpackage

`default_nettype wire

// File: rtl/hbd_front.sv
// ----------------------------------------------------------------------------
// hbd_front
// input stage: takes bin pairs, forms the bin product and tags the last bin
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_front #(
    parameter int COUNT_BITS = 20
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [COUNT_BITS-1:0]   i_count_a,
    input  wire logic [COUNT_BITS-1:0]   i_count_b,
    input  wire logic                    i_last,
    input  wire logic                    i_full,
    output logic                         o_push,
    output logic [2*COUNT_BITS-1:0]      o_prod,
    output logic [COUNT_BITS-1:0]        o_count_a,
    output logic [COUNT_BITS-1:0]        o_count_b,
    output logic                         o_last
);

    logic                    r_valid;
    logic [2*COUNT_BITS-1:0] r_prod;
    logic [COUNT_BITS-1:0]   r_count_a;
    logic [COUNT_BITS-1:0]   r_count_b;
    logic                    r_last;
    logic                    w_accept;

    assign o_ready  = !r_valid || !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = r_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prod    <= {{COUNT_BITS{1'b0}}, i_count_a} * {{COUNT_BITS{1'b0}}, i_count_b};
            r_count_a <= i_count_a;
            r_count_b <= i_count_b;
            r_last    <= i_last;
        end
    end

    assign o_prod    = r_prod;
    assign o_count_a = r_count_a;
    assign o_count_b = r_count_b;
    assign o_last    = r_last;

endmodule

`default_nettype wire

// File: rtl/hbd_fifo.sv
// ----------------------------------------------------------------------------
// hbd_fifo
// short register queue decoupling the front stage from the root pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_fifo #(
    parameter int WIDTH = 81
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0]             r_mem [hbd_pkg::QUEUE_DEPTH];
    logic [hbd_pkg::QUEUE_AW-1:0] r_wr;
    logic [hbd_pkg::QUEUE_AW-1:0] r_rd;
    logic [hbd_pkg::QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (hbd_pkg::QUEUE_AW + 1)'(hbd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            priority case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hbd_root_pipe.sv
// ----------------------------------------------------------------------------
// hbd_root_pipe
// pipelined per-bin fixed-point root with saturating totals and root sum
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_root_pipe #(
    parameter int COUNT_BITS = 20,
    parameter int TOTAL_W    = 26,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [2*COUNT_BITS-1:0]       i_prod,
    input  wire logic [COUNT_BITS-1:0]         i_count_a,
    input  wire logic [COUNT_BITS-1:0]         i_count_b,
    input  wire logic                          i_last,
    input  wire logic                          i_fin_busy,
    output logic                               o_fin_start,
    output logic [TOTAL_W-1:0]                 o_total_a,
    output logic [TOTAL_W-1:0]                 o_total_b,
    output logic [TOTAL_W+FRAC_BITS-1:0]       o_sum
);

    localparam int PW    = 2 * COUNT_BITS;
    localparam int RTW   = COUNT_BITS + FRAC_BITS;
    localparam int REMW  = RTW + 2;
    localparam int SUM_W = TOTAL_W + FRAC_BITS;

    logic [PW-1:0]         r_x     [RTW];
    logic [REMW-1:0]       r_rem   [RTW];
    logic [RTW-1:0]        r_root  [RTW+1];
    logic [COUNT_BITS-1:0] r_a     [RTW+1];
    logic [COUNT_BITS-1:0] r_b     [RTW+1];
    logic                  r_last  [RTW+1];
    logic                  r_v     [RTW+1];

    logic [TOTAL_W-1:0]    r_total_a;
    logic [TOTAL_W-1:0]    r_total_b;
    logic [SUM_W-1:0]      r_sum;
    logic [TOTAL_W-1:0]    n_total_a;
    logic [TOTAL_W-1:0]    n_total_b;
    logic [SUM_W-1:0]      n_sum;
    logic [TOTAL_W:0]      w_add_a;
    logic [TOTAL_W:0]      w_add_b;
    logic [SUM_W:0]        w_add_s;
    logic                  w_en;
    logic                  w_out;

    // hold everything while a finished comparison waits for the finisher
    assign w_en    = !(r_v[RTW] && r_last[RTW] && i_fin_busy);
    assign o_ready = w_en;
    assign w_out   = w_en && r_v[RTW];

    // stage 0 load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x[0]    <= i_prod;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_a[0]    <= i_count_a;
            r_b[0]    <= i_count_b;
            r_last[0] <= i_last;
        end
    end

    // one root digit per stage
    for (genvar i = 0; i < RTW; i++) begin : g_step
        logic [REMW-1:0] w_remsh;
        logic [REMW-1:0] w_trial;
        logic [REMW-1:0] w_diff;
        logic            w_ge;

        always_comb begin
            w_remsh = {r_rem[i][REMW-3:0], r_x[i][PW-1 -: 2]};
            w_trial = {r_root[i], 2'b01};
            w_ge    = (w_remsh >= w_trial);
            w_diff  = w_remsh - w_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (w_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_root[i+1] <= {r_root[i][RTW-2:0], w_ge};
                r_a[i+1]    <= r_a[i];
                r_b[i+1]    <= r_b[i];
                r_last[i+1] <= r_last[i];
            end
        end

        if (i < RTW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_x[i+1]   <= r_x[i] << 2;
                    r_rem[i+1] <= w_ge ? w_diff : w_remsh;
                end
            end
        end
    end

    // saturating accumulation at the pipe output
    always_comb begin
        w_add_a   = {1'b0, r_total_a} + {{(TOTAL_W + 1 - COUNT_BITS){1'b0}}, r_a[RTW]};
        w_add_b   = {1'b0, r_total_b} + {{(TOTAL_W + 1 - COUNT_BITS){1'b0}}, r_b[RTW]};
        w_add_s   = {1'b0, r_sum} + {{(SUM_W + 1 - RTW){1'b0}}, r_root[RTW]};
        n_total_a = w_add_a[TOTAL_W] ? '1 : w_add_a[TOTAL_W-1:0];
        n_total_b = w_add_b[TOTAL_W] ? '1 : w_add_b[TOTAL_W-1:0];
        n_sum     = w_add_s[SUM_W]   ? '1 : w_add_s[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_a <= '0;
            r_total_b <= '0;
            r_sum     <= '0;
        end else if (w_out) begin
            if (r_last[RTW]) begin
                r_total_a <= '0;
                r_total_b <= '0;
                r_sum     <= '0;
            end else begin
                r_total_a <= n_total_a;
                r_total_b <= n_total_b;
                r_sum     <= n_sum;
            end
        end
    end

    assign o_fin_start = w_out && r_last[RTW];
    assign o_total_a   = n_total_a;
    assign o_total_b   = n_total_b;
    assign o_sum       = n_sum;

endmodule

`default_nettype wire

// File: rtl/hbd_isqrt.sv
// ----------------------------------------------------------------------------
// hbd_isqrt
// iterative digit-by-digit integer root, one result bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_isqrt #(
    parameter int VW = 52,
    parameter int RW = 34
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [VW-1:0]              i_value,
    input  wire logic [$clog2(RW+1)-1:0]    i_steps,
    output logic                            o_done,
    output logic [RW-1:0]                   o_root
);

    localparam int CW   = $clog2(RW + 1);
    localparam int REMW = RW + 2;

    logic [VW-1:0]   r_x;
    logic [REMW-1:0] r_rem;
    logic [RW-1:0]   r_root;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [REMW-1:0] w_remsh;
    logic [REMW-1:0] w_trial;
    logic            w_ge;

    // leading zero pairs of a short value only add zero root bits
    always_comb begin
        w_remsh = {r_rem[REMW-3:0], r_x[VW-1 -: 2]};
        w_trial = {r_root, 2'b01};
        w_ge    = (w_remsh >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= r_x << 2;
            r_rem  <= w_ge ? (w_remsh - w_trial) : w_remsh;
            r_root <= {r_root[RW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// File: rtl/hbd_finish.sv
// ----------------------------------------------------------------------------
// hbd_finish
// end-of-comparison sequencer: denominator root, ratio division, final root
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_finish #(
    parameter int TOTAL_W   = 26,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [TOTAL_W-1:0]            i_total_a,
    input  wire logic [TOTAL_W-1:0]            i_total_b,
    input  wire logic [TOTAL_W+FRAC_BITS-1:0]  i_sum,
    output logic                               o_busy,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [hbd_pkg::DIST_W-1:0]         o_distance,
    output logic                               o_empty_error
);

    localparam int SUM_W = TOTAL_W + FRAC_BITS;
    localparam int PW    = 2 * TOTAL_W;
    localparam int RW    = TOTAL_W + ((FRAC_BITS > hbd_pkg::DIST_FRAC) ?
                                      FRAC_BITS : hbd_pkg::DIST_FRAC);
    localparam int SCW   = $clog2(RW + 1);
    localparam int DW    = SUM_W + hbd_pkg::RATIO_SHIFT;
    localparam int DCW   = $clog2(DW);
    localparam logic [SCW-1:0] STEPS_DEN  = SCW'(TOTAL_W + FRAC_BITS);
    localparam logic [SCW-1:0] STEPS_DIST = SCW'(TOTAL_W + hbd_pkg::DIST_FRAC);

    hbd_pkg::t_fin_state r_state;
    hbd_pkg::t_fin_state n_state;

    logic [TOTAL_W-1:0]         r_ta;
    logic [TOTAL_W-1:0]         r_tb;
    logic [SUM_W-1:0]           r_sum;
    logic                       r_err;
    logic [PW-1:0]              r_prod;
    logic [SUM_W-1:0]           r_den;
    logic [SUM_W-1:0]           r_rem;
    logic [DW-1:0]              r_quo;
    logic [DCW-1:0]             r_cnt;
    logic [hbd_pkg::DIST_W-1:0] r_v;
    logic [hbd_pkg::DIST_W-1:0] r_dist;
    logic                       r_out_valid;
    logic [hbd_pkg::DIST_W-1:0] r_out_dist;
    logic                       r_out_err;

    logic                       w_empty;
    logic                       w_sq_start;
    logic [PW-1:0]              w_sq_value;
    logic [SCW-1:0]             w_sq_steps;
    logic                       w_sq_done;
    logic [RW-1:0]              w_sq_root;
    logic                       w_load_out;
    logic [SUM_W:0]             w_remsh;
    logic [SUM_W:0]             w_diff;
    logic                       w_ge;
    logic [hbd_pkg::DIST_W-1:0] w_ratio;

    assign w_empty = (i_total_a == '0) || (i_total_b == '0);

    hbd_isqrt #(
        .VW (PW),
        .RW (RW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_value (w_sq_value),
        .i_steps (w_sq_steps),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hbd_pkg::FIN_IDLE: begin
                if (i_start) begin
                    n_state = w_empty ? hbd_pkg::FIN_DONE : hbd_pkg::FIN_MUL;
                end
            end
            hbd_pkg::FIN_MUL:    n_state = hbd_pkg::FIN_DSTART;
            hbd_pkg::FIN_DSTART: n_state = hbd_pkg::FIN_DROOT;
            hbd_pkg::FIN_DROOT: begin
                if (w_sq_done) begin
                    n_state = hbd_pkg::FIN_DIV;
                end
            end
            hbd_pkg::FIN_DIV: begin
                if (r_cnt == DCW'(DW - 1)) begin
                    n_state = hbd_pkg::FIN_CLAMP;
                end
            end
            hbd_pkg::FIN_CLAMP:  n_state = hbd_pkg::FIN_QSTART;
            hbd_pkg::FIN_QSTART: n_state = hbd_pkg::FIN_QROOT;
            hbd_pkg::FIN_QROOT: begin
                if (w_sq_done) begin
                    n_state = hbd_pkg::FIN_DONE;
                end
            end
            hbd_pkg::FIN_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = hbd_pkg::FIN_IDLE;
                end
            end
            default: n_state = hbd_pkg::FIN_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_busy     = (r_state != hbd_pkg::FIN_IDLE);
        w_sq_start = 1'b0;
        w_sq_value = r_prod;
        w_sq_steps = STEPS_DEN;
        w_load_out = 1'b0;
        unique case (r_state)
            hbd_pkg::FIN_DSTART: begin
                w_sq_start = 1'b1;
            end
            hbd_pkg::FIN_QSTART: begin
                w_sq_start = 1'b1;
                w_sq_value = {{(PW - hbd_pkg::DIST_W){1'b0}}, r_v};
                w_sq_steps = STEPS_DIST;
            end
            hbd_pkg::FIN_DONE: begin
                w_load_out = !r_out_valid || i_ready;
            end
            default: begin
                w_sq_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbd_pkg::FIN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // restoring division step and ratio clamp
    always_comb begin
        w_remsh = {r_rem, r_quo[DW-1]};
        w_diff  = w_remsh - {1'b0, r_den};
        w_ge    = (w_remsh >= {1'b0, r_den});
        w_ratio = (r_quo > {{(DW - hbd_pkg::DIST_W){1'b0}}, hbd_pkg::ONE_Q16}) ?
                  hbd_pkg::ONE_Q16 : r_quo[hbd_pkg::DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            hbd_pkg::FIN_IDLE: begin
                if (i_start) begin
                    r_ta  <= i_total_a;
                    r_tb  <= i_total_b;
                    r_sum <= i_sum;
                    r_err <= w_empty;
                end
            end
            hbd_pkg::FIN_MUL: begin
                r_prod <= {{TOTAL_W{1'b0}}, r_ta} * {{TOTAL_W{1'b0}}, r_tb};
            end
            hbd_pkg::FIN_DROOT: begin
                if (w_sq_done) begin
                    r_den <= w_sq_root[SUM_W-1:0];
                    r_rem <= '0;
                    r_quo <= {r_sum, {hbd_pkg::RATIO_SHIFT{1'b0}}};
                    r_cnt <= '0;
                end
            end
            hbd_pkg::FIN_DIV: begin
                r_rem <= w_ge ? w_diff[SUM_W-1:0] : w_remsh[SUM_W-1:0];
                r_quo <= {r_quo[DW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            hbd_pkg::FIN_CLAMP: begin
                r_v <= hbd_pkg::ONE_Q16 - w_ratio;
            end
            hbd_pkg::FIN_QROOT: begin
                if (w_sq_done) begin
                    r_dist <= w_sq_root[hbd_pkg::DIST_W-1:0];
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // result register, holds while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_dist <= r_err ? '0 : r_dist;
            r_out_err  <= r_err;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_distance    = r_out_dist;
    assign o_empty_error = r_out_err;

endmodule

`default_nettype wire

// File: rtl/histogram_bhattacharyya_distance.sv
// ----------------------------------------------------------------------------
// histogram_bhattacharyya_distance
// streams two histograms as bin-count pairs and returns their distance
// ----------------------------------------------------------------------------
// slave side: one beat per bin pair, count_a in the low tdata bits, count_b
// above it, tlast on the final bin of a comparison. master side: one beat per
// comparison, q0.16 distance in tdata (65536 is 1.0), tuser flags an empty
// histogram, in which case the distance is 0.
// throughput: one bin beat per cycle while no stall holds the pipe, set by the
// fully pipelined per-bin root (one stage per root bit, COUNT_BITS+FRAC_BITS
// stages). a tlast beat passes the front stage, queue and root pipe, then the
// finishing sequence: the denominator root, the ratio division, the final
// root and the result register.
// bins of the next comparison stream in while the previous one finishes; a
// second tlast beat waits at the root pipe output until the finisher is free,
// so back-to-back comparisons cost at least the finishing sequence each.
// a stalled master holds the result register and, behind it, the finisher,
// then the pipe and the queue, and finally tready drops.
// reset (synchronous, active low) empties all stages and clears the totals.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_bhattacharyya_distance #(
    parameter int COUNT_BITS = 20,
    parameter int MAX_BINS   = 64,
    parameter int FRAC_BITS  = 8,
    localparam int IN_TDATA_W = ((2 * COUNT_BITS + 7) / 8) * 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // bin pair beats
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]           i_s_tdata,   // count_a, count_b
    input  wire logic                            i_s_tlast,   // last_bin
    // result beats
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [hbd_pkg::OUT_TDATA_W-1:0]      o_m_tdata,   // distance
    output logic [0:0]                           o_m_tuser    // empty_error
);

    localparam int TOTAL_W = COUNT_BITS + $clog2(MAX_BINS);
    localparam int SUM_W   = TOTAL_W + FRAC_BITS;
    localparam int PW      = 2 * COUNT_BITS;
    localparam int QW      = PW + 2 * COUNT_BITS + 1;

    // front stage to queue
    logic                     front_push;
    logic [PW-1:0]            front_prod;
    logic [COUNT_BITS-1:0]    front_a;
    logic [COUNT_BITS-1:0]    front_b;
    logic                     front_last;
    logic                     fifo_full;
    logic                     fifo_valid;
    logic                     fifo_pop;
    logic [QW-1:0]            fifo_wdata;
    logic [QW-1:0]            fifo_rdata;

    // root pipe to finisher
    logic                     pipe_ready;
    logic                     fin_start;
    logic                     fin_busy;
    logic [TOTAL_W-1:0]       fin_total_a;
    logic [TOTAL_W-1:0]       fin_total_b;
    logic [SUM_W-1:0]         fin_sum;

    logic [hbd_pkg::DIST_W-1:0] res_distance;
    logic                       res_empty;

    // product is formed right at the input register
    hbd_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_count_a (i_s_tdata[COUNT_BITS-1:0]),
        .i_count_b (i_s_tdata[2*COUNT_BITS-1:COUNT_BITS]),
        .i_last    (i_s_tlast),
        .i_full    (fifo_full),
        .o_push    (front_push),
        .o_prod    (front_prod),
        .o_count_a (front_a),
        .o_count_b (front_b),
        .o_last    (front_last)
    );

    assign fifo_wdata = {front_last, front_b, front_a, front_prod};
    assign fifo_pop   = fifo_valid && pipe_ready;

    hbd_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (fifo_wdata),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_valid (fifo_valid),
        .o_data  (fifo_rdata)
    );

    // per-bin root and saturating accumulators
    hbd_root_pipe #(
        .COUNT_BITS (COUNT_BITS),
        .TOTAL_W    (TOTAL_W),
        .FRAC_BITS  (FRAC_BITS)
    ) u_root_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (fifo_valid),
        .o_ready     (pipe_ready),
        .i_prod      (fifo_rdata[PW-1:0]),
        .i_count_a   (fifo_rdata[PW+COUNT_BITS-1:PW]),
        .i_count_b   (fifo_rdata[PW+2*COUNT_BITS-1:PW+COUNT_BITS]),
        .i_last      (fifo_rdata[QW-1]),
        .i_fin_busy  (fin_busy),
        .o_fin_start (fin_start),
        .o_total_a   (fin_total_a),
        .o_total_b   (fin_total_b),
        .o_sum       (fin_sum)
    );

    // denominator root, ratio, final root and result register
    hbd_finish #(
        .TOTAL_W   (TOTAL_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_finish (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (fin_start),
        .i_total_a     (fin_total_a),
        .i_total_b     (fin_total_b),
        .i_sum         (fin_sum),
        .o_busy        (fin_busy),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_distance    (res_distance),
        .o_empty_error (res_empty)
    );

    assign o_m_tdata = {{(hbd_pkg::OUT_TDATA_W - hbd_pkg::DIST_W){1'b0}}, res_distance};
    assign o_m_tuser = res_empty;

    // a comparison is only handed over to an idle finisher
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_start |-> !fin_busy)
        else $error("finisher started while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_start |=> fin_busy)
        else $error("finisher did not pick up a finished comparison");

    // the front stage never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push |-> !fifo_full)
        else $error("queue push while full");

    // an empty histogram always reports distance zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (res_distance == '0))
        else $error("empty histogram with nonzero distance");

endmodule

`default_nettype wire

// File: dv/tb_histogram_bhattacharyya_distance.sv
// ----------------------------------------------------------------------------
// tb_histogram_bhattacharyya_distance
// self-checking bench for the streamed bhattacharyya histogram distance
// ----------------------------------------------------------------------------
// bin pair beats go in on the slave side, one per bin. every accepted beat
// also updates a local model of the totals and the root product sum; on a
// tlast beat the model works out the distance and the empty flag and queues
// them. every result beat taken on the master side is compared with the
// oldest queued distance. directed histograms cover the edge cases, a long
// saturating pair covers accumulator overflow, then random histograms run
// under several source idle and sink stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_histogram_bhattacharyya_distance;

    // block geometry at the default parameters
    localparam int COUNT_W  = 20;
    localparam int TOTAL_W  = 26;
    localparam int SUM_W    = 34;
    localparam int FRAC_W   = 8;
    localparam int IN_W     = ((2 * COUNT_W + 7) / 8) * 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam longint unsigned TOTAL_SAT = (64'd1 << TOTAL_W) - 1;
    localparam longint unsigned SUM_SAT   = (64'd1 << SUM_W) - 1;
    localparam longint unsigned UNITY     = 64'(hbd_pkg::ONE_Q16);
    // settle time after the last result, well above the finishing latency
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [hbd_pkg::DIST_W-1:0] distance;
        logic                       empty_error;
    } t_bhat_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [IN_W-1:0]                 i_s_tdata;   // count_a, count_b
    logic                            i_s_tlast;   // last_bin
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [hbd_pkg::OUT_TDATA_W-1:0] o_m_tdata;   // distance
    logic [0:0]                      o_m_tuser;   // empty_error

    // model state, mirrors the block accumulators
    longint unsigned sum_count_a;
    longint unsigned sum_count_b;
    longint unsigned sum_bin_roots;

    t_bhat_result pending_distances[$];
    t_bhat_result oldest_distance;
    int           error_count = 0;
    int           src_idle_pct = 0;
    int           sink_stall_pct = 0;

    histogram_bhattacharyya_distance uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // floor(sqrt(v * 4^frac)), restoring digit-by-digit root over 64-bit v
    function automatic longint unsigned scaled_isqrt(input longint unsigned v,
                                                     input int unsigned frac);
        longint unsigned root;
        longint unsigned rem;
        longint unsigned trial;
        longint unsigned two_bits;
        root = 0;
        rem  = 0;
        for (int unsigned k = 0; k < 32 + frac; k++) begin
            two_bits = (k < 32) ? ((v >> (62 - 2 * k)) & 64'd3) : 64'd0;
            rem      = (rem << 2) | two_bits;
            trial    = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // accumulators stick at all-ones instead of wrapping
    function automatic longint unsigned add_clamped(input longint unsigned acc,
                                                    input longint unsigned add,
                                                    input longint unsigned top);
        if (add > top || acc > top - add)
            return top;
        return acc + add;
    endfunction

    // fold one accepted bin pair into the model, queue a result on the last bin
    task automatic model_bin(input logic [COUNT_W-1:0] count_a,
                             input logic [COUNT_W-1:0] count_b,
                             input logic last_bin);
        longint unsigned denom;
        longint unsigned ratio;
        longint unsigned dist_q16;
        t_bhat_result    res;
        sum_count_a   = add_clamped(sum_count_a, 64'(count_a), TOTAL_SAT);
        sum_count_b   = add_clamped(sum_count_b, 64'(count_b), TOTAL_SAT);
        sum_bin_roots = add_clamped(sum_bin_roots,
                                    scaled_isqrt(64'(count_a) * 64'(count_b), FRAC_W),
                                    SUM_SAT);
        if (last_bin) begin
            if (sum_count_a == 0 || sum_count_b == 0) begin
                // empty histogram on either side
                res.distance    = '0;
                res.empty_error = 1'b1;
            end else begin
                denom = scaled_isqrt(sum_count_a * sum_count_b, FRAC_W);
                ratio = (denom == 0) ? UNITY : (sum_bin_roots << 16) / denom;
                // rounding can push the ratio past one
                if (ratio > UNITY)
                    ratio = UNITY;
                dist_q16 = scaled_isqrt(UNITY - ratio, 8);
                if (dist_q16 > UNITY)
                    dist_q16 = UNITY;
                res.distance    = dist_q16[hbd_pkg::DIST_W-1:0];
                res.empty_error = 1'b0;
            end
            pending_distances = {pending_distances, res};
            sum_count_a   = 0;
            sum_count_b   = 0;
            sum_bin_roots = 0;
        end
    endtask

    // one bin pair beat; tvalid stays up afterwards so beats can run back to back
    task automatic send_bin(input logic [COUNT_W-1:0] count_a,
                            input logic [COUNT_W-1:0] count_b,
                            input logic last_bin);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {count_b, count_a};
        i_s_tlast  <= last_bin;
        // values read right after the edge are the ones the block sampled
        do @(posedge i_clk); while (!o_s_tready);
        model_bin(count_a, count_b, last_bin);
    endtask

    // sink side: tready toggles at random with the current stall rate
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // result beat checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_distances.size() == 0) begin
                $display("%0t: unexpected result beat, tdata %h tuser %b",
                         $time, o_m_tdata, o_m_tuser);
                error_count++;
            end else begin
                oldest_distance = pending_distances.pop_front();
                if (o_m_tdata !== {{(hbd_pkg::OUT_TDATA_W-hbd_pkg::DIST_W){1'b0}},
                                   oldest_distance.distance}) begin
                    $display("%0t: distance mismatch, expected %0d got %0d (tdata %h)",
                             $time, oldest_distance.distance,
                             o_m_tdata[hbd_pkg::DIST_W-1:0], o_m_tdata);
                    error_count++;
                end
                if (o_m_tuser !== oldest_distance.empty_error) begin
                    $display("%0t: empty flag mismatch, expected %b got %b",
                             $time, oldest_distance.empty_error, o_m_tuser);
                    error_count++;
                end
            end
        end
    end

    // edge cases, no idling on either side
    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // single bin, identical counts: distance 0
        send_bin(20'd1, 20'd1, 1'b1);
        // both sides empty
        send_bin(20'd0, 20'd0, 1'b1);
        // one side empty
        send_bin(20'd0, 20'd5, 1'b1);
        send_bin(20'd5, 20'd0, 1'b1);
        // largest counts in a single bin
        send_bin(COUNT_MAX, COUNT_MAX, 1'b1);
        // disjoint histograms: distance reaches 1.0
        send_bin(COUNT_MAX, 20'd0, 1'b0);
        send_bin(20'd0, COUNT_MAX, 1'b1);
        // very lopsided bins
        send_bin(20'd1, COUNT_MAX, 1'b0);
        send_bin(COUNT_MAX, 20'd1, 1'b1);
        // zero bin in the middle
        send_bin(20'd3, 20'd3, 1'b0);
        send_bin(20'd0, 20'd0, 1'b0);
        send_bin(20'd7, 20'd9, 1'b1);
        // empty first histogram over two bins
        send_bin(20'd0, 20'd4, 1'b0);
        send_bin(20'd0, 20'd9, 1'b1);
        // alternating bit patterns
        send_bin(20'hAAAAA, 20'h55555, 1'b0);
        send_bin(20'h55555, 20'hAAAAA, 1'b1);
    endtask

    // long runs of full bins push totals and root sum into saturation
    task automatic test_saturation();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int k = 0; k < 70; k++)
            send_bin(COUNT_MAX, COUNT_MAX, k == 69);
        for (int k = 0; k < 66; k++)
            send_bin(COUNT_MAX, 20'($urandom_range(20'hF0000, 20'hFFFFF)), k == 65);
    endtask

    // random histograms of mixed shape, length and count range
    task automatic test_random(input int n_bins, input int src_pct, input int sink_pct);
        int              sent;
        int              len;
        int              shape;
        int unsigned     span;
        logic [COUNT_W:0] wide;
        logic [COUNT_W-1:0] count_a;
        logic [COUNT_W-1:0] count_b;
        bit              empty_a;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        sent = 0;
        while (sent < n_bins) begin
            len     = ($urandom_range(15) == 0) ? $urandom_range(17, 64)
                                                : $urandom_range(1, 12);
            shape   = $urandom_range(9);
            span    = 1 << $urandom_range(1, COUNT_W);
            empty_a = 1'($urandom_range(1));
            for (int k = 0; k < len; k++) begin
                count_a = 20'($urandom_range(span - 1));
                count_b = 20'($urandom_range(span - 1));
                if (shape >= 4 && shape <= 6) begin
                    // near-identical histograms, small distances
                    wide    = {1'b0, count_a} + 21'($urandom_range(3));
                    count_b = wide[COUNT_W] ? COUNT_MAX : wide[COUNT_W-1:0];
                end else if (shape == 7 || shape == 8) begin
                    // sparse bins
                    if ($urandom_range(1)) count_a = '0;
                    if ($urandom_range(1)) count_b = '0;
                end else if (shape == 9) begin
                    // one whole side empty
                    if (empty_a) count_a = '0;
                    else count_b = '0;
                end
                send_bin(count_a, count_b, k == len - 1);
                sent++;
            end
        end
    endtask

    // stop sending, collect every result, then watch for strays
    task automatic test_drain();
        i_s_tvalid <= 1'b0;
        while (pending_distances.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        sum_count_a   = 0;
        sum_count_b   = 0;
        sum_bin_roots = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        i_m_tready <= 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_saturation();
        test_random(160, 0, 0);     // back to back
        test_random(160, 65, 0);    // source mostly idle
        test_random(160, 0, 65);    // sink mostly stalled
        test_random(160, 25, 25);   // both
        test_drain();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
